/* hw/rtl/lse_pkg.sv */
// Package for the LIFO stack engine: operation and status codes,
// request/result payload structs, controller state and control structs.
// No dependencies.
`default_nettype none

package lse_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned DEPTH_W = 7;

  typedef enum logic [1:0] {
    FUNC_PUSH  = 2'd0,
    FUNC_POP   = 2'd1,
    FUNC_LIST  = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_LIST
  } state_e;

  typedef struct packed {
    func_e                     func;
    logic signed [WORD_W-1:0]  push_value;
  } req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0]  word_out;
    logic [1:0]                status;
    logic [DEPTH_W-1:0]        depth_now;
    logic                      last;
  } res_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic is_list;
    logic empty;
    logic ptr_zero;
  } sts_t;

endpackage

`default_nettype wire

/* hw/rtl/lse_ctrl.sv */
// Controller state machine for the LIFO stack engine.
// Drives datapath commands and busy; depends on lse_pkg.
`default_nettype none

module lse_ctrl
  import lse_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts_i.is_list && !sts_i.empty && !sts_i.ptr_zero) begin
          state_d = S_LIST;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_LIST: begin
        if (sts_i.ptr_zero) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    case (state_q)
      S_IDLE: begin
        busy       = 1'b0;
        cmd_o.load = start;
      end
      S_DECODE: begin
        cmd_o.exec = 1'b1;
      end
      S_LIST: begin
        cmd_o.step = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/lse_datapath.sv */
// Datapath for the LIFO stack engine: word store, count, read pointer
// and registered result. Depends on lse_pkg.
`default_nettype none

module lse_datapath
  import lse_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t cmd_i,
  input  req_t req_i,
  output sts_t sts_o,
  output logic res_valid_o,
  output res_t res_o
);

  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(STACK_DEPTH);

  logic [WORD_W-1:0] mem [STACK_DEPTH];
  logic [WORD_W-1:0] rdata_q;

  logic [CNT_W-1:0]  count_q, count_d;
  logic [IDX_W-1:0]  ptr_q, ptr_d;
  func_e             op_q;
  logic [WORD_W-1:0] val_q;

  logic              valid_q, valid_d;
  logic              sel_q, sel_d;
  status_e           status_q, status_d;
  logic [CNT_W-1:0]  depth_q, depth_d;
  logic              last_q, last_d;
  logic              wr_en;

  logic full, empty, ptr_zero;

  assign full     = (count_q == CNT_W'(STACK_DEPTH));
  assign empty    = (count_q == '0);
  assign ptr_zero = (ptr_q == '0);

  assign sts_o.is_list  = (op_q == FUNC_LIST);
  assign sts_o.empty    = empty;
  assign sts_o.ptr_zero = ptr_zero;

  always_comb begin
    count_d  = count_q;
    ptr_d    = ptr_q;
    valid_d  = 1'b0;
    sel_d    = 1'b0;
    status_d = STAT_OK;
    last_d   = 1'b1;
    wr_en    = 1'b0;
    if (cmd_i.load) begin
      ptr_d = IDX_W'(count_q - CNT_W'(1));
    end
    if (cmd_i.exec) begin
      valid_d = 1'b1;
      case (op_q)
        FUNC_PUSH: begin
          if (full) begin
            status_d = STAT_FULL;
          end else begin
            wr_en   = 1'b1;
            count_d = count_q + CNT_W'(1);
          end
        end
        FUNC_POP: begin
          if (empty) begin
            status_d = STAT_EMPTY;
          end else begin
            sel_d   = 1'b1;
            count_d = count_q - CNT_W'(1);
          end
        end
        FUNC_LIST: begin
          if (empty) begin
            status_d = STAT_EMPTY;
          end else begin
            sel_d  = 1'b1;
            last_d = ptr_zero;
            ptr_d  = ptr_q - IDX_W'(1);
          end
        end
        FUNC_CLEAR: begin
          count_d = '0;
        end
        default: begin
          count_d = count_q;
        end
      endcase
    end
    if (cmd_i.step) begin
      valid_d = 1'b1;
      sel_d   = 1'b1;
      last_d  = ptr_zero;
      ptr_d   = ptr_q - IDX_W'(1);
    end
    depth_d = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    if (cmd_i.load) begin
      op_q  <= req_i.func;
      val_q <= req_i.push_value;
    end
    if (valid_d) begin
      sel_q    <= sel_d;
      status_q <= status_d;
      depth_q  <= depth_d;
      last_q   <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[count_q[IDX_W-1:0]] <= val_q;
    end
    rdata_q <= mem[ptr_q];
  end

  assign res_valid_o     = valid_q;
  assign res_o.word_out  = sel_q ? rdata_q : '0;
  assign res_o.status    = status_q;
  assign res_o.depth_now = DEPTH_W'(depth_q);
  assign res_o.last      = last_q;

endmodule

`default_nettype wire

/* hw/rtl/lifo_stack_engine_top.sv */
// Top level of the LIFO stack engine: controller plus datapath.
// Depends on lse_pkg, lse_ctrl and lse_datapath.
//
//   port group           direction  handshake
//   start, req_i         in         transfer when start high and busy low
//   busy                 out        high while an operation is in progress
//   res_valid_o, res_o   out        high with each result, receiver cannot stall
//
// Push, pop and clear go through decode back to idle; the result passes the
// state register and the result register. List stays in the list state
// until the read pointer is zero and streams one word per cycle from the
// single memory read port; a stack of under two words skips the list state.
// Reset empties the stack at once; store contents stay undefined.
// Results are never held off, so nothing stalls the engine.
`default_nettype none

module lifo_stack_engine_top
  import lse_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic res_valid_o,
  output res_t res_o
);

  cmd_t cmd;
  sts_t sts;

  lse_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  lse_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_i       (req_i),
    .sts_o       (sts),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire

/* test/lse_checker.sv */
// Checker for the LIFO stack engine: watches the request and result channels,
// keeps its own stack image, predicts every result and compares field by field.
// Depends on lse_pkg.
module lse_checker
  import lse_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic busy_i,
  input  req_t req_i,
  input  logic res_valid_i,
  input  res_t res_i,
  output int   err_cnt_o,
  output int   pending_o,
  output int   checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [WORD_W-1:0] stack_image [STACK_DEPTH];
  int unsigned              image_level;
  res_t                     expected_res_q [$];
  int                       mismatch_count = 0;
  int                       pending_count = 0;
  int                       compared_count = 0;

  assign err_cnt_o = mismatch_count;
  assign pending_o = pending_count;
  assign checked_o = compared_count;

  function automatic res_t make_res(logic signed [WORD_W-1:0] word, status_e st,
                                    int unsigned depth, logic is_last);
    res_t r;
    r.word_out  = word;
    r.status    = st;
    r.depth_now = DEPTH_W'(depth);
    r.last      = is_last;
    return r;
  endfunction

  task automatic predict_stack_op(req_t r);
    case (r.func)
      FUNC_PUSH: begin
        if (image_level >= STACK_DEPTH) begin
          expected_res_q.push_back(make_res('0, STAT_FULL, image_level, 1'b1));
        end else begin
          stack_image[image_level] = r.push_value;
          image_level++;
          expected_res_q.push_back(make_res('0, STAT_OK, image_level, 1'b1));
        end
      end
      FUNC_POP: begin
        if (image_level == 0) begin
          expected_res_q.push_back(make_res('0, STAT_EMPTY, 0, 1'b1));
        end else begin
          image_level--;
          expected_res_q.push_back(make_res(stack_image[image_level], STAT_OK,
                                            image_level, 1'b1));
        end
      end
      FUNC_LIST: begin
        if (image_level == 0) begin
          expected_res_q.push_back(make_res('0, STAT_EMPTY, 0, 1'b1));
        end else begin
          for (int i = image_level; i > 0; i--) begin
            expected_res_q.push_back(make_res(stack_image[i-1], STAT_OK, image_level,
                                              i == 1));
          end
        end
      end
      default: begin
        image_level = 0;
        expected_res_q.push_back(make_res('0, STAT_OK, 0, 1'b1));
      end
    endcase
  endtask

  task automatic compare_result(res_t got);
    res_t want;
    if (expected_res_q.size() == 0) begin
      $error("unexpected result: word_out %0d status %0d depth_now %0d last %0d",
             got.word_out, got.status, got.depth_now, got.last);
      mismatch_count++;
    end else begin
      want = expected_res_q.pop_front();
      compared_count++;
      if (got.word_out !== want.word_out) begin
        $error("word_out: expected %0d, got %0d", want.word_out, got.word_out);
        mismatch_count++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        mismatch_count++;
      end
      if (got.depth_now !== want.depth_now) begin
        $error("depth_now: expected %0d, got %0d", want.depth_now, got.depth_now);
        mismatch_count++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        mismatch_count++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_level = 0;
      expected_res_q.delete();
    end else begin
      if (start_i && !busy_i) predict_stack_op(req_i);
      if (res_valid_i) compare_result(res_i);
    end
    pending_count = expected_res_q.size();
  end

endmodule

/* test/lifo_stack_engine_top_tb.sv */
// Testbench top for the LIFO stack engine: clock, reset, directed and random
// operation stimulus with sender gaps, and the verdict.
// Depends on lse_pkg, lifo_stack_engine_top and lse_checker.
module lifo_stack_engine_top_tb;
  import lse_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STACK_DEPTH = 64;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req;
  logic res_valid;
  res_t res;
  int   err_cnt;
  int   pending;
  int   checked;

  int   send_idle_pct;
  int   fill_level;
  int   push_cnt, pop_cnt, list_cnt, clear_cnt;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  lifo_stack_engine_top #(.STACK_DEPTH(STACK_DEPTH)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  lse_checker #(.STACK_DEPTH(STACK_DEPTH)) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .busy_i     (busy),
    .req_i      (req),
    .res_valid_i(res_valid),
    .res_i      (res),
    .err_cnt_o  (err_cnt),
    .pending_o  (pending),
    .checked_o  (checked)
  );

  // Drive one operation and hold it until the transfer.
  task automatic issue_op(func_e f, logic signed [WORD_W-1:0] v);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    start          = 1'b1;
    req.func       = f;
    req.push_value = v;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
    case (f)
      FUNC_PUSH: begin
        push_cnt++;
        if (fill_level < STACK_DEPTH) fill_level++;
      end
      FUNC_POP: begin
        pop_cnt++;
        if (fill_level > 0) fill_level--;
      end
      FUNC_LIST: list_cnt++;
      default: begin
        clear_cnt++;
        fill_level = 0;
      end
    endcase
  endtask

  task automatic random_op();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) issue_op(FUNC_PUSH, $urandom());
    else if (pick < 80) issue_op(FUNC_POP, $urandom());
    else if (pick < 93) issue_op(FUNC_LIST, $urandom());
    else issue_op(FUNC_CLEAR, $urandom());
  endtask

  // Fill to the top, push past it, dump and unwind a little.
  task automatic fill_to_full();
    while (fill_level < STACK_DEPTH) issue_op(FUNC_PUSH, $urandom());
    issue_op(FUNC_PUSH, $urandom());
    issue_op(FUNC_PUSH, $urandom());
    issue_op(FUNC_LIST, $urandom());
    repeat ($urandom_range(1, 6)) issue_op(FUNC_POP, $urandom());
    issue_op(FUNC_LIST, $urandom());
  endtask

  initial begin
    rst_ni        = 1'b0;
    start         = 1'b0;
    req           = '0;
    send_idle_pct = 24;
    fill_level    = 0;
    push_cnt      = 0;
    pop_cnt       = 0;
    list_cnt      = 0;
    clear_cnt     = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    issue_op(FUNC_CLEAR, 32'sd0);
    issue_op(FUNC_POP, 32'sd0);
    issue_op(FUNC_LIST, 32'sd0);
    issue_op(FUNC_PUSH, 32'sh7FFF_FFFF);
    issue_op(FUNC_PUSH, 32'sh8000_0000);
    issue_op(FUNC_PUSH, 32'sd0);
    issue_op(FUNC_PUSH, -32'sd1);
    issue_op(FUNC_PUSH, 32'sh5555_5555);
    issue_op(FUNC_PUSH, 32'shAAAA_AAAA);
    issue_op(FUNC_LIST, -32'sd1);
    issue_op(FUNC_POP, -32'sd1);
    issue_op(FUNC_POP, 32'sd0);
    issue_op(FUNC_LIST, 32'sd0);
    issue_op(FUNC_CLEAR, -32'sd1);
    issue_op(FUNC_LIST, 32'sd0);
    issue_op(FUNC_CLEAR, 32'sd0);
    issue_op(FUNC_PUSH, $urandom());
    issue_op(FUNC_PUSH, $urandom());
    issue_op(FUNC_POP, 32'sd0);
    issue_op(FUNC_POP, 32'sd0);
    issue_op(FUNC_POP, 32'sd0);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 24 : (ph == 1) ? 60 : 0;
      repeat (35) random_op();
      if (ph != 1) fill_to_full();
    end

    start = 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Covered %0d operations (%0d push, %0d pop, %0d list, %0d clear), %0d results",
             push_cnt + pop_cnt + list_cnt + clear_cnt, push_cnt, pop_cnt, list_cnt,
             clear_cnt, checked);
    $display("Stack filled to %0d entries and pushed past full twice.", STACK_DEPTH);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
